### hw/rtl/wibt_pkg.sv
// shared types, codes and helpers of the ipv4 wildcard block table
// no dependencies; used by wibt_engine, wildcard_ip_block_table_unit, wibt_result_checker and the testbench
package wibt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [31:0] LOOPBACK_ADDR = 32'h0100_007F;
    localparam logic [7:0]  OCTET_MASK    = 8'hFF;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_LOOPBACK = 2'd2
    } status_t;

    // one request item as handed to the engine
    typedef struct packed {
        req_t        req;
        logic [31:0] address;
        logic [3:0]  wild;
    } item_t;

    // result of one request
    typedef struct packed {
        logic        valid;
        logic        blocked;
        status_t     status;
        logic [6:0]  count;
    } result_t;

    // engine status seen by the top level
    typedef struct packed {
        logic idle;
        logic full;
    } eng_stat_t;

    // ones on compared octets, zeros on wildcard octets
    function automatic logic [31:0] care_mask(input logic [3:0] wild);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 4; i++) begin
            m[i*8 +: 8] = wild[i] ? 8'h00 : OCTET_MASK;
        end
        return m;
    endfunction

endpackage

### hw/rtl/wildcard_ip_block_table_unit.sv
// top level of the ipv4 wildcard block table: stream ports and result register
// depends on wibt_pkg and wibt_engine
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: req_type, tdata: address, wild_octets
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: blocked, status, entry_count
//
// lookup and remove walk the held entries one per cycle through the single read
// port of the entry memory; a lookup stops early at the first matching entry
// add and clear go straight to their result without a walk of the table
// the engine is back to idle in the cycle after its result is loaded
// reset empties the table at once, no clearing pass; entry contents are not reset
// a result waits in the output register while the next item is taken; the
// engine holds its next result until that register is free
module wildcard_ip_block_table_unit #(
    parameter int TABLE_DEPTH = wibt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] address, [35:32] wild_octets, [39:36] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] blocked, [2:1] status, [9:3] entry_count
);

    wibt_pkg::item_t     item;
    wibt_pkg::result_t   res;
    wibt_pkg::eng_stat_t stat;
    logic                start;
    logic                res_ready;
    logic                res_load;

    logic                out_valid_reg;
    logic [9:0]          out_data_reg;

    // an item is taken whenever the engine is idle
    assign s_axis_tready = stat.idle;
    assign start         = s_axis_tvalid && s_axis_tready;

    assign item.req     = wibt_pkg::req_t'(s_axis_tuser);
    assign item.address = s_axis_tdata[31:0];
    assign item.wild    = s_axis_tdata[35:32];

    // output register is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;
    assign res_load  = res.valid && res_ready;

    wibt_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .res_ready (res_ready),
        .res       (res),
        .stat      (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= {res.count, res.status, res.blocked};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

`ifndef SYNTHESIS
    // the engine goes busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("engine still ready after accepting an item");

    // a dropped add is only reported on a full table
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (res.status == wibt_pkg::ST_FULL)) |-> stat.full)
        else $error("full status reported on a table that is not full");

    // a result is only loaded while the engine is not idle
    a_load_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !stat.idle)
        else $error("result loaded from an idle engine");
`endif

endmodule

### hw/rtl/wibt_engine.sv
// request sequencer and entry memory of the ipv4 wildcard block table
// depends on wibt_pkg
module wibt_engine #(
    parameter int TABLE_DEPTH = wibt_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  wibt_pkg::item_t    item,
    input  logic               res_ready,
    output wibt_pkg::result_t  res,
    output wibt_pkg::eng_stat_t stat
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]  wild;
        logic [31:0] address;
    } entry_t;

    // entry memory, one write and one registered read port
    entry_t mem [TABLE_DEPTH];

    state_t            state_reg, state_next;
    wibt_pkg::req_t    req_reg, req_next;
    logic [31:0]       addr_reg, addr_next;
    logic [3:0]        wild_reg, wild_next;
    logic [31:0]       norm_reg, norm_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              blocked_reg, blocked_next;
    wibt_pkg::status_t status_reg, status_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_idx;
    entry_t            rd_data_reg;

    logic [31:0]       in_norm;
    logic [31:0]       rd_care;
    logic              issue;
    logic              hit;
    logic              same;
    logic              full;
    logic [31:0]       count_wide;

    assign in_norm = item.address & wibt_pkg::care_mask(item.wild);
    assign rd_care = wibt_pkg::care_mask(rd_data_reg.wild);
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit     = pend_reg && ((addr_reg & rd_care) == (rd_data_reg.address & rd_care));
    assign same    = pend_reg && (rd_data_reg.address == norm_reg)
                     && (rd_data_reg.wild == wild_reg);

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        addr_next    = addr_reg;
        wild_next    = wild_reg;
        norm_next    = norm_reg;
        rd_ptr_next  = rd_ptr_reg;
        keep_next    = keep_reg;
        pend_next    = pend_reg;
        count_next   = count_reg;
        blocked_next = blocked_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_idx       = count_reg[IDX_W-1:0];
        wr_data      = '{wild: item.wild, address: in_norm};
        rd_idx       = rd_ptr_reg[IDX_W-1:0];
        issue        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = item.req;
                    addr_next    = item.address;
                    wild_next    = item.wild;
                    norm_next    = in_norm;
                    blocked_next = 1'b0;
                    status_next  = wibt_pkg::ST_DONE;
                    rd_ptr_next  = '0;
                    keep_next    = '0;
                    pend_next    = 1'b0;
                    case (item.req)
                        wibt_pkg::REQ_LOOKUP, wibt_pkg::REQ_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        wibt_pkg::REQ_ADD:
                        begin
                            if (in_norm == wibt_pkg::LOOPBACK_ADDR)
                            begin
                                status_next = wibt_pkg::ST_LOOPBACK;
                            end
                            else if (full)
                            begin
                                status_next = wibt_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_DONE;
                        end
                        wibt_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, its data checked in the next
                issue       = (rd_ptr_reg < count_reg);
                rd_ptr_next = rd_ptr_reg + CNT_W'(issue);
                pend_next   = issue;
                if (req_reg == wibt_pkg::REQ_LOOKUP)
                begin
                    if (hit)
                    begin
                        blocked_next = 1'b1;
                        pend_next    = 1'b0;
                        state_next   = S_DONE;
                    end
                    else if (!issue && !pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // compaction: survivors move down to the keep slot,
                    // which never passes the slot being read
                    if (pend_reg && !same)
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = keep_reg[IDX_W-1:0];
                        wr_data   = rd_data_reg;
                        keep_next = keep_reg + CNT_W'(1);
                    end
                    if (!issue && !pend_reg)
                    begin
                        count_next = keep_reg;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            rd_ptr_reg  <= '0;
            keep_reg    <= '0;
            req_reg     <= wibt_pkg::REQ_LOOKUP;
            blocked_reg <= 1'b0;
            status_reg  <= wibt_pkg::ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            rd_ptr_reg  <= rd_ptr_next;
            keep_reg    <= keep_next;
            req_reg     <= req_next;
            blocked_reg <= blocked_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        wild_reg <= wild_next;
        norm_reg <= norm_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    assign count_wide  = 32'(count_reg);
    assign res.valid   = (state_reg == S_DONE);
    assign res.blocked = blocked_reg;
    assign res.status  = status_reg;
    assign res.count   = count_wide[6:0];

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.full = full;

endmodule

### sim/wibt_result_checker.sv
// result checker for the ipv4 wildcard block table: watches both stream channels,
// predicts each result from its own copy of the table and compares field by field
// depends on wibt_pkg
`timescale 1ns / 1ps

module wibt_result_checker
    import wibt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] address, [35:32] wild_octets, [39:36] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [0] blocked, [2:1] status, [9:3] entry_count
    output int          mismatches,
    output int          awaiting
);

    typedef struct packed {
        logic       blocked;
        status_t    status;
        logic [6:0] entry_count;
    } table_answer_t;

    // shadow of the block table
    logic [31:0]   held_addr [DEPTH];
    logic [3:0]    held_wild [DEPTH];
    int            held_count;

    table_answer_t answers_due [$];
    int            result_no;

    // ones on the octets that take part in a compare
    function automatic logic [31:0] octet_keep(input logic [3:0] wild);
        return {{8{~wild[3]}}, {8{~wild[2]}}, {8{~wild[1]}}, {8{~wild[0]}}};
    endfunction

    function automatic table_answer_t table_predict(input req_t req, input logic [31:0] addr,
                                                    input logic [3:0] wild);
        table_answer_t ans;
        logic [31:0]   norm;
        int            kept;
        ans.blocked = 1'b0;
        ans.status  = ST_DONE;
        norm        = addr & octet_keep(wild);
        case (req)
            REQ_LOOKUP:
            begin
                // stored entries already hold zeros on their wildcard octets
                for (int i = 0; i < held_count && !ans.blocked; i++)
                begin
                    if ((addr & octet_keep(held_wild[i])) == held_addr[i])
                        ans.blocked = 1'b1;
                end
            end
            REQ_ADD:
            begin
                // loopback refusal wins over the full check
                if (norm == LOOPBACK_ADDR)
                    ans.status = ST_LOOPBACK;
                else if (held_count >= DEPTH)
                    ans.status = ST_FULL;
                else
                begin
                    held_addr[held_count] = norm;
                    held_wild[held_count] = wild;
                    held_count++;
                end
            end
            REQ_REMOVE:
            begin
                // drop every identical entry, keep the order of the rest
                kept = 0;
                for (int i = 0; i < held_count; i++)
                begin
                    if (!(held_addr[i] == norm && held_wild[i] == wild))
                    begin
                        held_addr[kept] = held_addr[i];
                        held_wild[kept] = held_wild[i];
                        kept++;
                    end
                end
                held_count = kept;
            end
            default:
                held_count = 0;
        endcase
        ans.entry_count = 7'(held_count);
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns result %0d: %s got %0d want %0d", $time, result_no, what, got, want);
        mismatches++;
    endtask

    task automatic check_answer(input logic [15:0] word);
        table_answer_t want;
        result_no++;
        if (answers_due.size() == 0)
            report_mismatch("result with no request pending", 32'(word), 32'd0);
        else
        begin
            want = answers_due.pop_front();
            if (word[0] !== want.blocked)
                report_mismatch("blocked", 32'(word[0]), 32'(want.blocked));
            if (word[2:1] !== want.status)
                report_mismatch("status", 32'(word[2:1]), 32'(want.status));
            if (word[9:3] !== want.entry_count)
                report_mismatch("entry_count", 32'(word[9:3]), 32'(want.entry_count));
        end
    endtask

    // results are checked before the item taken at the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answers_due.delete();
            held_count = 0;
            mismatches = 0;
            result_no  = 0;
            awaiting  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_answer(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                answers_due.insert(answers_due.size(),
                                   table_predict(req_t'(s_axis_tuser), s_axis_tdata[31:0],
                                                 s_axis_tdata[35:32]));
            awaiting <= answers_due.size();
        end
    end

endmodule

### sim/wildcard_ip_block_table_unit_tb.sv
// testbench top of the ipv4 wildcard block table: clock, reset, request stimulus,
// bursty sender, stalling receiver, watchdog and verdict
// depends on wibt_pkg, wildcard_ip_block_table_unit and wibt_result_checker
`timescale 1ns / 1ps

module wildcard_ip_block_table_unit_tb;
    import wibt_pkg::*;

    localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
    localparam int TOTAL_ITEMS    = 800;
    localparam int WATCHDOG_LIMIT = 3000;   // quiet cycles; the slowest item is a walk of a full table plus stalls
    localparam int TAIL_CYCLES    = 100;    // longer than a walk of a full table
    localparam int KNOWN_MAX      = 48;     // patterns remembered for lookups and removes

    // receiver stall patterns
    localparam int RX_STREAM = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // [31:0] address, [35:32] wild_octets, [39:36] zero
    logic [1:0]  s_axis_tuser = REQ_LOOKUP;  // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [0] blocked, [2:1] status, [9:3] entry_count

    int mismatches;
    int awaiting;

    // sender state
    int burst_left = 0;
    int sent = 0;

    // added patterns, reused so lookups hit and removes find their entry
    logic [31:0] known_addr [$];
    logic [3:0]  known_wild [$];

    // receiver state
    int rx_mode = RX_STREAM;
    int rx_left = 0;

    int quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    wildcard_ip_block_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    wibt_result_checker #(
        .DEPTH(TABLE_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .mismatches   (mismatches),
        .awaiting     (awaiting)
    );

    // receiver: switches between always ready, coin flip and mostly stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_mode       <= RX_STREAM;
            rx_left       <= 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(RX_STREAM, RX_SPARSE);
                rx_left <= $urandom_range(16, 160);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_STREAM: m_axis_tready <= 1'b1;
                RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** wildcard_ip_block_table_unit: FAILED **");
                $finish;
            end
        end
    end

    // one request item; valid stays high across a burst, drops only at its end
    task automatic push_request(input req_t req, input logic [31:0] addr,
                                input logic [3:0] wild);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(20, 90)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, wild, addr};
        s_axis_tuser  <= req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
        sent++;
    endtask

    // hold the sender until every pending result has come back
    task automatic drain_pause();
        if (burst_left != 0)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    // octet values that hit the interesting corners more often
    function automatic logic [7:0] pick_octet();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        return {pick_octet(), pick_octet(), pick_octet(), pick_octet()};
    endfunction

    // random content on the wildcard octets, the pattern stays the same
    function automatic logic [31:0] scramble_wild(input logic [31:0] addr,
                                                  input logic [3:0] wild);
        logic [31:0] a;
        a = addr;
        for (int i = 0; i < 4; i++)
        begin
            if (wild[i])
                a[i*8 +: 8] = 8'($urandom);
        end
        return a;
    endfunction

    task automatic remember(input logic [31:0] addr, input logic [3:0] wild);
        known_addr.insert(known_addr.size(), addr);
        known_wild.insert(known_wild.size(), wild);
        if (known_addr.size() > KNOWN_MAX)
        begin
            void'(known_addr.pop_front());
            void'(known_wild.pop_front());
        end
    endtask

    task automatic add_item();
        logic [31:0] addr;
        logic [3:0]  wild;
        int          idx;
        if (known_addr.size() != 0 && $urandom_range(0, 9) < 3)
        begin
            // duplicate of an earlier entry, possibly with other wildcard content
            idx  = $urandom_range(0, known_addr.size() - 1);
            wild = known_wild[idx];
            addr = scramble_wild(known_addr[idx], wild);
        end
        else
        begin
            wild = ($urandom_range(0, 4) < 2) ? 4'h0 : 4'($urandom_range(0, 15));
            addr = pick_addr();
        end
        remember(addr, wild);
        push_request(REQ_ADD, addr, wild);
    endtask

    // loopback attempts: mostly wildcards on the zero octets, which keep the refusal
    task automatic loopback_item();
        logic [3:0] wild;
        if ($urandom_range(0, 3) == 0)
            wild = 4'($urandom_range(0, 15));
        else
            wild = {1'b0, 2'($urandom_range(0, 3)), 1'b0};
        push_request(REQ_ADD, LOOPBACK_ADDR, wild);
    endtask

    task automatic lookup_item();
        logic [31:0] addr;
        int          idx;
        if (known_addr.size() != 0 && $urandom_range(0, 99) < 65)
        begin
            idx  = $urandom_range(0, known_addr.size() - 1);
            addr = scramble_wild(known_addr[idx], known_wild[idx]);
            // near miss on one bit
            if ($urandom_range(0, 9) < 3)
                addr = addr ^ (32'h1 << $urandom_range(0, 31));
        end
        else
            addr = pick_addr();
        push_request(REQ_LOOKUP, addr, 4'($urandom_range(0, 15)));
    endtask

    task automatic remove_item();
        logic [31:0] addr;
        logic [3:0]  wild;
        int          idx;
        if (known_addr.size() != 0 && $urandom_range(0, 3) != 0)
        begin
            idx  = $urandom_range(0, known_addr.size() - 1);
            wild = known_wild[idx];
            addr = scramble_wild(known_addr[idx], wild);
        end
        else
        begin
            wild = 4'($urandom_range(0, 15));
            addr = pick_addr();
        end
        push_request(REQ_REMOVE, addr, wild);
    endtask

    // mostly adds, enough to run the table into full
    task automatic fill_phase(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                loopback_item();
            else if (r < 12)
                lookup_item();
            else
                add_item();
        end
    endtask

    task automatic mixed_phase(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                lookup_item();
            else if (r < 68)
                add_item();
            else if (r < 72)
                loopback_item();
            else if (r < 97)
                remove_item();
            else
                push_request(REQ_CLEAR, $urandom, 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic drain_phase(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 7)
                remove_item();
            else
                lookup_item();
        end
    endtask

    // unshaped requests
    task automatic noise_phase(input int n);
        repeat (n)
            push_request(req_t'($urandom_range(0, 3)), $urandom, 4'($urandom_range(0, 15)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        push_request(REQ_LOOKUP, 32'h0000_0000, 4'h0);    // empty table
        push_request(REQ_CLEAR,  32'hFFFF_FFFF, 4'hF);    // clear while empty
        push_request(REQ_ADD,    LOOPBACK_ADDR, 4'h0);    // loopback refused
        push_request(REQ_ADD,    LOOPBACK_ADDR, 4'b0110); // zero octets wildcarded: still refused
        push_request(REQ_ADD,    LOOPBACK_ADDR, 4'b1000); // 127.0.0.* accepted
        push_request(REQ_LOOKUP, LOOPBACK_ADDR, 4'h0);
        push_request(REQ_ADD,    32'hFFFF_FFFF, 4'h0);
        push_request(REQ_LOOKUP, 32'hFFFF_FFFF, 4'h0);
        push_request(REQ_LOOKUP, 32'hFFFF_FFFE, 4'h0);
        push_request(REQ_ADD,    32'hDEAD_BEEF, 4'b0101); // stored with octets 0 and 2 zeroed
        push_request(REQ_LOOKUP, 32'hDE55_BE66, 4'h0);
        push_request(REQ_REMOVE, 32'hDEAD_BEEF, 4'b0011); // other flags: nothing removed
        push_request(REQ_REMOVE, 32'hDE11_BE22, 4'b0101); // same normalized pattern
        push_request(REQ_LOOKUP, 32'hDE55_BE66, 4'h0);
        push_request(REQ_ADD,    32'h1234_5678, 4'hF);    // all wildcard
        push_request(REQ_ADD,    32'h0000_0000, 4'hF);    // duplicate of it
        push_request(REQ_LOOKUP, 32'h89AB_CDEF, 4'h0);
        push_request(REQ_REMOVE, 32'hFFFF_FFFF, 4'hF);    // removes both duplicates, compacts
        push_request(REQ_LOOKUP, 32'hFFFF_FFFF, 4'h0);
        push_request(REQ_LOOKUP, 32'h89AB_CDEF, 4'h0);
        push_request(REQ_CLEAR,  32'h5A5A_5A5A, 4'hA);
        push_request(REQ_LOOKUP, 32'hFFFF_FFFF, 4'hA);
        drain_pause();

        // run into the full table early on, loopback attempts included
        fill_phase(90);
        drain_pause();

        while (sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       fill_phase(60);
                1, 2:    mixed_phase(50);
                3:       drain_phase(40);
                4:       noise_phase(25);
                default:
                begin
                    push_request(REQ_CLEAR, $urandom, 4'($urandom_range(0, 15)));
                    fill_phase(80);
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                drain_pause();
        end

        drain_pause();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** wildcard_ip_block_table_unit: PASSED **");
        else
            $display("** wildcard_ip_block_table_unit: FAILED **");
        $finish;
    end

endmodule
